// ===== rtl/core/pf2r_pkg.sv =====
// shared types and constants for the pixel format to rgba8 converter
`timescale 1ns / 1ps

package pf2r_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned CHAN_W       = 8;
  localparam int unsigned MAG_W        = 24;
  localparam int unsigned SHIFT_W      = 6;
  localparam int unsigned PROD_W       = MAG_W + CHAN_W;
  localparam int unsigned CFG_INDEX_W  = 1;
  localparam int unsigned CFG_DATA_W   = 3;
  localparam int unsigned NUM_CHAN     = 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SWAP_RED_BLUE = 1'd1;

  typedef enum logic [2:0] {
    FMT_RGBA8      = 3'd0,
    FMT_R8         = 3'd1,
    FMT_RGBA16F    = 3'd2,
    FMT_RGBA32F    = 3'd3,
    FMT_R11G11B10F = 3'd4,
    FMT_RG16F      = 3'd5,
    FMT_R16F       = 3'd6,
    FMT_R32F       = 3'd7
  } fmt_t;

  // how the back end turns a channel into a byte
  typedef enum logic [1:0] {
    CH_ZERO  = 2'd0,
    CH_FULL  = 2'd1,
    CH_BYTE  = 2'd2,
    CH_SCALE = 2'd3
  } ch_kind_t;

  typedef struct packed {
    ch_kind_t             kind;
    logic [MAG_W-1:0]     mag;
    logic [SHIFT_W-1:0]   sh;
  } ch_desc_t;

  // channel 0 red, 1 green, 2 blue, 3 alpha
  typedef struct packed {
    ch_desc_t [NUM_CHAN-1:0] ch;
    logic                    end_of_row;
    logic                    end_of_frame;
  } item_t;

endpackage

// ===== rtl/core/pixel_format_to_rgba8.sv =====
// top level of the pixel format to rgba8 converter
`timescale 1ns / 1ps

// Converts one source pixel per transaction into one rgba8 pixel.
// Input side is a queue: the source holds in_word_0..3 and the end marks and
// raises push; the transaction happens on a clock edge with push high and
// full low. Result side is a queue too: while empty is low the oldest pixel
// sits on out_red/green/blue/alpha with row_done and frame_done, and it goes
// at an edge with pop high.
// The front end decodes the pixel combinationally into a small queue; the
// back end multiplies each float mantissa by 255 in one stage and rounds and
// shifts in the next. A pushed pixel passes the queue and both stages
// before it can be popped. One pixel per cycle is sustained while pop keeps
// taking; pushes continue while a result waits, until the queue and the two
// back-end stages are filled, then full rises until pop frees a place.
// cfg_wr_en writes register cfg_index (0 pixel format, 1 red/blue swap) from
// cfg_data; write only while the block is idle.
// Synchronous reset empties everything and sets format rgba8, no swap.
module pixel_format_to_rgba8
  import pf2r_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic [WORD_W-1:0]      in_word_0,
  input  logic [WORD_W-1:0]      in_word_1,
  input  logic [WORD_W-1:0]      in_word_2,
  input  logic [WORD_W-1:0]      in_word_3,
  input  logic                   in_end_of_row,
  input  logic                   in_end_of_frame,
  output logic                   empty,
  input  logic                   pop,
  output logic [CHAN_W-1:0]      out_red,
  output logic [CHAN_W-1:0]      out_green,
  output logic [CHAN_W-1:0]      out_blue,
  output logic [CHAN_W-1:0]      out_alpha,
  output logic                   out_row_done,
  output logic                   out_frame_done,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  fmt_t  pixel_format_r, pixel_format_nxt;
  logic  swap_red_blue_r, swap_red_blue_nxt;

  item_t             front_item;
  item_t             q_item;
  logic              q_not_empty;
  logic              q_take;
  logic              back_valid;
  logic [CHAN_W-1:0] back_byte [NUM_CHAN];

  always_comb begin
    pixel_format_nxt  = pixel_format_r;
    swap_red_blue_nxt = swap_red_blue_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PIXEL_FORMAT:  pixel_format_nxt  = fmt_t'(cfg_data[2:0]);
        REG_SWAP_RED_BLUE: swap_red_blue_nxt = cfg_data[0];
        default:           pixel_format_nxt  = pixel_format_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r  <= FMT_RGBA8;
      swap_red_blue_r <= 1'b0;
    end else begin
      pixel_format_r  <= pixel_format_nxt;
      swap_red_blue_r <= swap_red_blue_nxt;
    end
  end

  pf2r_front u_front (
    .pixel_format  (pixel_format_r),
    .swap_red_blue (swap_red_blue_r),
    .word_0        (in_word_0),
    .word_1        (in_word_1),
    .word_2        (in_word_2),
    .word_3        (in_word_3),
    .end_of_row    (in_end_of_row),
    .end_of_frame  (in_end_of_frame),
    .item          (front_item)
  );

  pf2r_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (push),
    .wr_item   (front_item),
    .full      (full),
    .rd_en     (q_take),
    .rd_item   (q_item),
    .not_empty (q_not_empty)
  );

  pf2r_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (q_not_empty),
    .in_item          (q_item),
    .in_take          (q_take),
    .out_valid        (back_valid),
    .out_take         (pop),
    .out_byte         (back_byte),
    .out_end_of_row   (out_row_done),
    .out_end_of_frame (out_frame_done)
  );

  assign empty     = !back_valid;
  assign out_red   = back_byte[0];
  assign out_green = back_byte[1];
  assign out_blue  = back_byte[2];
  assign out_alpha = back_byte[3];

endmodule

// ===== rtl/core/pf2r_front.sv =====
// front end: decodes the source pixel into per-channel byte descriptors
`timescale 1ns / 1ps

module pf2r_front
  import pf2r_pkg::*;
(
  input  fmt_t              pixel_format,
  input  logic              swap_red_blue,
  input  logic [WORD_W-1:0] word_0,
  input  logic [WORD_W-1:0] word_1,
  input  logic [WORD_W-1:0] word_2,
  input  logic [WORD_W-1:0] word_3,
  input  logic              end_of_row,
  input  logic              end_of_frame,
  output item_t             item
);

  function automatic ch_desc_t const_desc(input ch_kind_t k);
    ch_desc_t d;
    d.kind = k;
    d.mag  = '0;
    d.sh   = '0;
    return d;
  endfunction

  function automatic ch_desc_t byte_desc(input logic [CHAN_W-1:0] b);
    ch_desc_t d;
    d.kind = CH_BYTE;
    d.mag  = {{(MAG_W-CHAN_W){1'b0}}, b};
    d.sh   = '0;
    return d;
  endfunction

  // value = mag * 2^-sh; only shifts 24..33 survive the clamps
  function automatic ch_desc_t f32_desc(input logic [31:0] bits);
    ch_desc_t   d;
    logic [7:0] e;
    logic [7:0] sh_full;
    e       = bits[30:23];
    sh_full = 8'd150 - e;
    d       = const_desc(CH_ZERO);
    if (e == 8'hFF) begin
      d.kind = (bits[22:0] != '0 || bits[31]) ? CH_ZERO : CH_FULL;
    end else if (bits[31] || e == 8'd0 || e < 8'd117) begin
      d.kind = CH_ZERO;
    end else if (e >= 8'd127) begin
      d.kind = CH_FULL;
    end else begin
      d.kind = CH_SCALE;
      d.mag  = {1'b1, bits[22:0]};
      d.sh   = sh_full[SHIFT_W-1:0];
    end
    return d;
  endfunction

  function automatic ch_desc_t f16_desc(input logic [15:0] h);
    ch_desc_t   d;
    logic [4:0] e;
    logic [5:0] sh_full;
    e       = h[14:10];
    sh_full = 6'd25 - {1'b0, e};
    d       = const_desc(CH_ZERO);
    if (e == 5'd31) begin
      d.kind = (h[9:0] != '0 || h[15]) ? CH_ZERO : CH_FULL;
    end else if (h[15]) begin
      d.kind = CH_ZERO;
    end else if (e == 5'd0) begin
      if (h[9:0] != '0) begin
        d.kind = CH_SCALE;
        d.mag  = {{(MAG_W-10){1'b0}}, h[9:0]};
        d.sh   = 6'd24;
      end
    end else if (e >= 5'd15) begin
      d.kind = CH_FULL;
    end else begin
      d.kind = CH_SCALE;
      d.mag  = {{(MAG_W-11){1'b0}}, 1'b1, h[9:0]};
      d.sh   = sh_full;
    end
    return d;
  endfunction

  // unsigned small float, six-bit mantissa when mb6 is set, else five-bit
  function automatic ch_desc_t uf_desc(input logic [4:0] e, input logic [5:0] m,
                                       input logic mb6);
    ch_desc_t   d;
    logic [5:0] sh_full;
    logic [6:0] hid;
    sh_full = (mb6 ? 6'd21 : 6'd20) - {1'b0, e};
    hid     = mb6 ? {1'b1, m} : {2'b01, m[4:0]};
    d       = const_desc(CH_ZERO);
    if (e == 5'd31) begin
      d.kind = (m != '0) ? CH_ZERO : CH_FULL;
    end else if (e == 5'd0) begin
      if (m != '0) begin
        d.kind = CH_SCALE;
        d.mag  = {{(MAG_W-6){1'b0}}, m};
        d.sh   = mb6 ? 6'd20 : 6'd19;
      end
    end else if (e >= 5'd15) begin
      d.kind = CH_FULL;
    end else begin
      d.kind = CH_SCALE;
      d.mag  = {{(MAG_W-7){1'b0}}, hid};
      d.sh   = sh_full;
    end
    return d;
  endfunction

  always_comb begin
    item.ch[0] = const_desc(CH_ZERO);
    item.ch[1] = const_desc(CH_ZERO);
    item.ch[2] = const_desc(CH_ZERO);
    item.ch[3] = const_desc(CH_FULL);
    item.end_of_row   = end_of_row;
    item.end_of_frame = end_of_frame;
    unique case (pixel_format)
      FMT_RGBA8: begin
        item.ch[0] = byte_desc(swap_red_blue ? word_0[23:16] : word_0[7:0]);
        item.ch[1] = byte_desc(word_0[15:8]);
        item.ch[2] = byte_desc(swap_red_blue ? word_0[7:0] : word_0[23:16]);
        item.ch[3] = byte_desc(word_0[31:24]);
      end
      FMT_R8: begin
        item.ch[0] = byte_desc(word_0[7:0]);
      end
      FMT_RGBA16F: begin
        item.ch[0] = f16_desc(word_0[15:0]);
        item.ch[1] = f16_desc(word_0[31:16]);
        item.ch[2] = f16_desc(word_1[15:0]);
        item.ch[3] = f16_desc(word_1[31:16]);
      end
      FMT_RGBA32F: begin
        item.ch[0] = f32_desc(word_0);
        item.ch[1] = f32_desc(word_1);
        item.ch[2] = f32_desc(word_2);
        item.ch[3] = f32_desc(word_3);
      end
      FMT_R11G11B10F: begin
        item.ch[0] = uf_desc(word_0[10:6], word_0[5:0], 1'b1);
        item.ch[1] = uf_desc(word_0[21:17], word_0[16:11], 1'b1);
        item.ch[2] = uf_desc(word_0[31:27], {1'b0, word_0[26:22]}, 1'b0);
      end
      FMT_RG16F: begin
        item.ch[0] = f16_desc(word_0[15:0]);
        item.ch[1] = f16_desc(word_0[31:16]);
      end
      FMT_R16F: begin
        item.ch[0] = f16_desc(word_0[15:0]);
      end
      FMT_R32F: begin
        item.ch[0] = f32_desc(word_0);
      end
      default: begin
        item.ch[0] = const_desc(CH_ZERO);
      end
    endcase
  end

endmodule

// ===== rtl/core/pf2r_queue.sv =====
// short queue of decoded pixels between front and back end
`timescale 1ns / 1ps

module pf2r_queue
  import pf2r_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  item_t wr_item,
  output logic  full,
  input  logic  rd_en,
  output item_t rd_item,
  output logic  not_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  item_t            store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_item   = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// ===== rtl/core/pf2r_back.sv =====
// back end: two-stage scale of channel descriptors to rgba8 bytes
`timescale 1ns / 1ps

module pf2r_back
  import pf2r_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  item_t             in_item,
  output logic              in_take,
  output logic              out_valid,
  input  logic              out_take,
  output logic [CHAN_W-1:0] out_byte [NUM_CHAN],
  output logic              out_end_of_row,
  output logic              out_end_of_frame
);

  localparam int unsigned SUM_W = PROD_W + 2;

  // stage 1: product mag * 255
  logic                v1_r, v1_nxt;
  ch_kind_t            kind1_r [NUM_CHAN];
  logic [PROD_W-1:0]   prod1_r [NUM_CHAN];
  logic [SHIFT_W-1:0]  sh1_r   [NUM_CHAN];
  logic                eor1_r, eof1_r;

  // stage 2: rounded, shifted byte
  logic                v2_r, v2_nxt;
  logic [CHAN_W-1:0]   byte2_r [NUM_CHAN];
  logic                eor2_r, eof2_r;

  logic                adv1, adv2;

  assign adv2    = !v2_r || out_take;
  assign adv1    = !v1_r || adv2;
  assign in_take = adv1 && in_valid;
  assign v1_nxt  = adv1 ? in_valid : v1_r;
  assign v2_nxt  = adv2 ? v1_r : v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        kind1_r[i] <= in_item.ch[i].kind;
        sh1_r[i]   <= in_item.ch[i].sh;
        if (in_item.ch[i].kind == CH_SCALE) begin
          prod1_r[i] <= PROD_W'(in_item.ch[i].mag) * PROD_W'(8'd255);
        end else begin
          prod1_r[i] <= PROD_W'(in_item.ch[i].mag[CHAN_W-1:0]);
        end
      end
      eor1_r <= in_item.end_of_row;
      eof1_r <= in_item.end_of_frame;
    end
  end

  always_ff @(posedge clk) begin
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] shifted;
    if (adv2) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        // round half up: add half an output step, then drop the fraction
        sum     = SUM_W'(prod1_r[i]) + (SUM_W'(1) << (sh1_r[i] - 1'b1));
        shifted = sum >> sh1_r[i];
        case (kind1_r[i])
          CH_ZERO:  byte2_r[i] <= '0;
          CH_FULL:  byte2_r[i] <= '1;
          CH_BYTE:  byte2_r[i] <= prod1_r[i][CHAN_W-1:0];
          default:  byte2_r[i] <= shifted[CHAN_W-1:0];
        endcase
      end
      eor2_r <= eor1_r;
      eof2_r <= eof1_r;
    end
  end

  assign out_valid        = v2_r;
  assign out_byte         = byte2_r;
  assign out_end_of_row   = eor2_r;
  assign out_end_of_frame = eof2_r;

endmodule
